// ===== rtl/wsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser package
// Phase codes, the result record and configuration constants shared by the
// parser core and the top level.
// ----------------------------------------------------------------------------
package wsfp_pkg;

   localparam int MAX_LEN_W = 31;
   localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(1 << 30);

   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_HDR0    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HDR1    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_EXT     = 3'd2;
   localparam logic [PHASE_W-1:0] PH_MASK    = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
   localparam logic [PHASE_W-1:0] PH_ERROR   = 3'd5;

   // Seven-bit length codes that announce an extended length.
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   typedef struct packed {
      logic [3:0] frame_opcode;
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
      logic       too_large;
   } rsp_type;

endpackage

// ===== rtl/websocket_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser top level
// Receive-side frame parser with an input register, the parser core and a
// result register.
// ----------------------------------------------------------------------------
// The parser takes one stream byte per clock cycle. A taken byte is held in the
// input register, and the parser core's step writes its result into the result
// register. Header, extended length and mask key bytes produce no result; each
// payload byte produces one unmasked result, an empty frame one marker, and an
// oversized frame one error result, after which bytes are absorbed without
// result until reset. The result register frees up in the same cycle its
// transfer completes, so the byte rate only drops while the result side is
// stalled and a byte that produces a result is waiting. The maximum length
// register must be written only while no transfer is in flight.
module websocket_frame_parser_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [3:0]                    rsp_frame_opcode,
   output logic [7:0]                    rsp_data_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last,
   output logic                          rsp_too_large,
   input  logic                          csr_wr_en,
   input  logic [wsfp_pkg::MAX_LEN_W-1:0] csr_wr_data
);
   import wsfp_pkg::*;

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic [MAX_LEN_W-1:0] max_len_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 out_free;
   logic                 step;
   logic                 emit;
   rsp_type              rsp_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // A byte that yields no result never waits on the result side.
   assign step      = in_valid_ff && (out_free || !emit);
   assign req_stall = in_valid_ff && !step;

   wsfp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (step),
      .in_byte (in_byte_ff),
      .max_len (max_len_ff),
      .emit    (emit),
      .rsp     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_opcode = rsp_ff.frame_opcode;
   assign rsp_data_byte    = rsp_ff.data_byte;
   assign rsp_byte_valid   = rsp_ff.byte_valid;
   assign rsp_last         = rsp_ff.last;
   assign rsp_too_large    = rsp_ff.too_large;

endmodule

// ===== rtl/wsfp_parse.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser core
// Header, extended length and mask key state, and the combinational step that
// turns one stream byte into at most one result.
// ----------------------------------------------------------------------------
module wsfp_parse (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step_en,
   input  logic [7:0]                            in_byte,
   input  logic [wsfp_pkg::MAX_LEN_W-1:0]        max_len,
   output logic                                  emit,
   output wsfp_pkg::rsp_type                     rsp
);
   import wsfp_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [3:0]         opcode_ff, opcode_in;
   logic               mask_ff, mask_in;
   logic [3:0]         ext_left_ff, ext_left_in;
   logic [63:0]        len_ff, len_in;
   logic [31:0]        key_ff, key_in;
   logic [1:0]         key_cnt_ff, key_cnt_in;
   logic [1:0]         pos_ff, pos_in;

   logic               len_done;
   logic               begin_pl;
   logic               too_big;
   logic [3:0]         ext_dec;
   logic [63:0]        len_dec;
   logic [7:0]         key_byte;

   always_comb begin
      phase_in    = phase_ff;
      opcode_in   = opcode_ff;
      mask_in     = mask_ff;
      ext_left_in = ext_left_ff;
      len_in      = len_ff;
      key_in      = key_ff;
      key_cnt_in  = key_cnt_ff;
      pos_in      = pos_ff;
      len_done    = 1'b0;
      begin_pl    = 1'b0;
      ext_dec     = ext_left_ff - {3'b0, (ext_left_ff != 4'd0)};
      len_dec     = len_ff - {63'b0, (len_ff != 64'd0)};
      key_byte    = 8'd0;
      emit        = 1'b0;
      rsp         = '0;
      rsp.frame_opcode = opcode_ff;

      case (phase_ff)
         PH_HDR0: begin
            opcode_in = in_byte[3:0];
            phase_in  = PH_HDR1;
         end
         PH_HDR1: begin
            mask_in = in_byte[7];
            len_in  = 64'd0;
            if (in_byte[6:0] == LEN_EXT16) begin
               ext_left_in = 4'd2;
               phase_in    = PH_EXT;
            end else if (in_byte[6:0] == LEN_EXT64) begin
               ext_left_in = 4'd8;
               phase_in    = PH_EXT;
            end else begin
               len_in   = {57'b0, in_byte[6:0]};
               len_done = 1'b1;
            end
         end
         PH_EXT: begin
            len_in      = {len_ff[55:0], in_byte};
            ext_left_in = ext_dec;
            len_done    = (ext_dec == 4'd0);
         end
         PH_MASK: begin
            key_in = {key_ff[23:0], in_byte};
            if (key_cnt_ff == 2'd3) begin
               key_cnt_in = 2'd0;
               begin_pl   = 1'b1;
            end else begin
               key_cnt_in = key_cnt_ff + 2'd1;
            end
         end
         PH_PAYLOAD: begin
            if (mask_ff) begin
               case (pos_ff)
                  2'd0:    key_byte = key_ff[31:24];
                  2'd1:    key_byte = key_ff[23:16];
                  2'd2:    key_byte = key_ff[15:8];
                  default: key_byte = key_ff[7:0];
               endcase
            end
            pos_in = pos_ff + 2'd1;
            len_in = len_dec;
            if (len_dec == 64'd0) begin
               phase_in = PH_HDR0;
            end
            emit           = 1'b1;
            rsp.data_byte  = in_byte ^ key_byte;
            rsp.byte_valid = 1'b1;
            rsp.last       = (len_dec == 64'd0);
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      // The length is checked in full as soon as its last byte arrives.
      too_big = (|len_in[63:MAX_LEN_W]) || (len_in[MAX_LEN_W-1:0] > max_len);

      if (len_done) begin
         if (too_big) begin
            phase_in      = PH_ERROR;
            emit          = 1'b1;
            rsp.too_large = 1'b1;
         end else if (mask_in) begin
            phase_in   = PH_MASK;
            key_cnt_in = 2'd0;
            key_in     = 32'd0;
         end else begin
            begin_pl = 1'b1;
         end
      end

      // An empty frame produces a single marker instead of payload.
      if (begin_pl) begin
         pos_in = 2'd0;
         if (len_in == 64'd0) begin
            phase_in = PH_HDR0;
            emit     = 1'b1;
            rsp.last = 1'b1;
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         opcode_ff   <= 4'd0;
         mask_ff     <= 1'b0;
         ext_left_ff <= 4'd0;
         len_ff      <= 64'd0;
         key_ff      <= 32'd0;
         key_cnt_ff  <= 2'd0;
         pos_ff      <= 2'd0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         opcode_ff   <= opcode_in;
         mask_ff     <= mask_in;
         ext_left_ff <= ext_left_in;
         len_ff      <= len_in;
         key_ff      <= key_in;
         key_cnt_ff  <= key_cnt_in;
         pos_ff      <= pos_in;
      end
   end

endmodule

// ===== rtl/wsfp_checker.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame parser port checker
// Checks the result channel of the top level as seen from its ports.
// ----------------------------------------------------------------------------
module wsfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_last,
   input logic       rsp_too_large
);

   // The result channel is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An error result carries neither data nor an end-of-frame mark.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_large) |-> (!rsp_byte_valid && !rsp_last && rsp_data_byte == 8'd0))
      else $error("malformed error result");

   // A result without a payload byte is either the error or an empty-frame marker.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_too_large != rsp_last))
      else $error("result is neither payload, marker nor error");

   // Once the error result is taken, no other result is presented directly after it.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_too_large) |=> !rsp_valid)
      else $error("result after the error result");

   // A stalled result stays valid and keeps its data byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data_byte)))
      else $error("stalled result changed");

endmodule

bind websocket_frame_parser_top wsfp_checker u_wsfp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_data_byte  (rsp_data_byte),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_last       (rsp_last),
   .rsp_too_large  (rsp_too_large)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser testbench
// Feeds frame byte streams through the valid/stall input channel and checks
// every result against a cycle-free parser model kept here or a table entry.
// A short directed table comes first, then random frames under a series of
// maximum length settings, and one oversized frame closes the run.
// ----------------------------------------------------------------------------
module tb;
   import wsfp_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES = 180;

   typedef enum {CHK_MODEL, CHK_NONE, CHK_GIVEN} chk_kind_type;

   typedef struct {
      logic [7:0]   b;
      chk_kind_type ck;
      rsp_type      r;
   } stim_row_type;

   localparam rsp_type NO_RSP = '0;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_in_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [3:0]           rsp_frame_opcode;
   logic [7:0]           rsp_data_byte;
   logic                 rsp_byte_valid;
   logic                 rsp_last;
   logic                 rsp_too_large;
   logic                 csr_wr_en = 1'b0;
   logic [MAX_LEN_W-1:0] csr_wr_data = '0;

   websocket_frame_parser_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_opcode (rsp_frame_opcode),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last         (rsp_last),
      .rsp_too_large    (rsp_too_large),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // Directed frames: a short unmasked frame, a masked frame whose payload
   // wraps the key, an empty masked frame and an empty 16-bit length frame.
   stim_row_type dir_rows [0:24] = '{
      '{8'h82, CHK_NONE, NO_RSP},
      '{8'h02, CHK_NONE, NO_RSP},
      '{8'hFF, CHK_GIVEN, rsp_type'{4'h2, 8'hFF, 1'b1, 1'b0, 1'b0}},
      '{8'h00, CHK_GIVEN, rsp_type'{4'h2, 8'h00, 1'b1, 1'b1, 1'b0}},
      '{8'h81, CHK_NONE, NO_RSP},
      '{8'h85, CHK_NONE, NO_RSP},
      '{8'hA5, CHK_NONE, NO_RSP},
      '{8'h5A, CHK_NONE, NO_RSP},
      '{8'hFF, CHK_NONE, NO_RSP},
      '{8'h00, CHK_NONE, NO_RSP},
      '{8'h48, CHK_MODEL, NO_RSP},
      '{8'h65, CHK_MODEL, NO_RSP},
      '{8'h6C, CHK_MODEL, NO_RSP},
      '{8'h6C, CHK_MODEL, NO_RSP},
      '{8'h6F, CHK_MODEL, NO_RSP},
      '{8'h8A, CHK_NONE, NO_RSP},
      '{8'h80, CHK_NONE, NO_RSP},
      '{8'h12, CHK_NONE, NO_RSP},
      '{8'h34, CHK_NONE, NO_RSP},
      '{8'h56, CHK_NONE, NO_RSP},
      '{8'h78, CHK_GIVEN, rsp_type'{4'hA, 8'h00, 1'b0, 1'b1, 1'b0}},
      '{8'h0F, CHK_NONE, NO_RSP},
      '{8'h7E, CHK_NONE, NO_RSP},
      '{8'h00, CHK_NONE, NO_RSP},
      '{8'h00, CHK_GIVEN, rsp_type'{4'hF, 8'h00, 1'b0, 1'b1, 1'b0}}
   };

   logic [MAX_LEN_W-1:0] lim_steps [0:9] = '{
      31'd0, 31'd1, 31'd125, 31'd126, 31'd127, 31'd300, 31'd65535,
      MAX_LEN_RESET, 31'h7FFF_FFFF, 31'd0
   };

   // Parser model state.
   logic [MAX_LEN_W-1:0] len_limit = MAX_LEN_RESET;
   logic [PHASE_W-1:0]   ph = PH_HDR0;
   logic [3:0]           hdr_opcode = '0;
   logic                 masked_frame = 1'b0;
   logic [3:0]           ext_left = '0;
   logic [63:0]          frame_len = '0;
   logic [31:0]          mask_key = '0;
   logic [1:0]           key_cnt = '0;
   logic [1:0]           pay_pos = '0;

   rsp_type parsed_q [$];
   chk_kind_type cur_ck = CHK_MODEL;
   rsp_type cur_given = '0;

   bit req_gaps_on = 1'b1;
   bit stall_on = 1'b1;
   int stall_left = 0;
   int bytes_sent = 0;
   int results_checked = 0;
   int mismatches = 0;
   int idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit payload_start(output rsp_type r);
      r = '0;
      r.frame_opcode = hdr_opcode;
      pay_pos = '0;
      if (frame_len == 0) begin
         ph = PH_HDR0;
         r.last = 1'b1;
         return 1'b1;
      end
      ph = PH_PAYLOAD;
      return 1'b0;
   endfunction

   // The length is checked as soon as it is complete, before any mask key.
   function automatic bit length_complete(output rsp_type r);
      r = '0;
      r.frame_opcode = hdr_opcode;
      if (frame_len > {33'd0, len_limit}) begin
         ph = PH_ERROR;
         r.too_large = 1'b1;
         return 1'b1;
      end
      if (masked_frame) begin
         ph = PH_MASK;
         key_cnt = '0;
         mask_key = '0;
         return 1'b0;
      end
      return payload_start(r);
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, output rsp_type r);
      logic [7:0] key_b;
      r = '0;
      r.frame_opcode = hdr_opcode;
      case (ph)
         PH_HDR0: begin
            hdr_opcode = b[3:0];
            ph = PH_HDR1;
            return 1'b0;
         end
         PH_HDR1: begin
            masked_frame = b[7];
            frame_len = '0;
            if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
               ext_left = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
               ph = PH_EXT;
               return 1'b0;
            end
            frame_len = {57'd0, b[6:0]};
            return length_complete(r);
         end
         PH_EXT: begin
            frame_len = {frame_len[55:0], b};
            if (ext_left > 0) ext_left--;
            if (ext_left == 0) return length_complete(r);
            return 1'b0;
         end
         PH_MASK: begin
            mask_key = {mask_key[23:0], b};
            if (key_cnt == 2'd3) begin
               key_cnt = '0;
               return payload_start(r);
            end
            key_cnt++;
            return 1'b0;
         end
         PH_PAYLOAD: begin
            key_b = masked_frame ? mask_key[8 * (3 - int'(pay_pos)) +: 8] : 8'h00;
            pay_pos++;
            if (frame_len > 0) frame_len--;
            if (frame_len == 0) ph = PH_HDR0;
            r.data_byte = b ^ key_b;
            r.byte_valid = 1'b1;
            r.last = (frame_len == 0);
            return 1'b1;
         end
         default: begin
            ph = PH_ERROR;
            return 1'b0;
         end
      endcase
   endfunction

   // Prediction, result checking and the watchdog share one edge process so
   // that an expectation is always queued before its result can be checked.
   always @(posedge clock) begin : check_proc
      rsp_type pred;
      rsp_type got;
      rsp_type want;
      bit      has;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            has = parse_byte(req_in_byte, pred);
            case (cur_ck)
               CHK_MODEL: if (has) parsed_q = {parsed_q, pred};
               CHK_GIVEN: parsed_q = {parsed_q, cur_given};
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_frame_opcode, rsp_data_byte, rsp_byte_valid, rsp_last, rsp_too_large};
            results_checked++;
            if (parsed_q.size() == 0) begin
               mismatches++;
               $display("%0t: expected no result, got op=%h data=%h bv=%b last=%b big=%b",
                        $time, got.frame_opcode, got.data_byte, got.byte_valid,
                        got.last, got.too_large);
            end else begin
               want = parsed_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  $display("%0t: expected op=%h data=%h bv=%b last=%b big=%b",
                           $time, want.frame_opcode, want.data_byte, want.byte_valid,
                           want.last, want.too_large);
                  $display("%0t: got      op=%h data=%h bv=%b last=%b big=%b",
                           $time, got.frame_opcode, got.data_byte, got.byte_valid,
                           got.last, got.too_large);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_on && stall_left == 0) stall_left = gap_len();
      if (stall_on && stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_byte(input logic [7:0] b, input chk_kind_type ck = CHK_MODEL,
                            input rsp_type given = '0);
      int gap;
      gap = req_gaps_on ? gap_len() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      cur_ck <= ck;
      cur_given <= given;
      do @(posedge clock); while (req_stall !== 1'b0);
      bytes_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (parsed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [MAX_LEN_W-1:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      len_limit = v;
   endtask

   // Form 0 is the 7-bit length, form 1 the 16-bit and form 2 the 64-bit one.
   task automatic send_header(input logic [7:0] b0, input logic [63:0] len, input int form,
                              input bit masked, input logic [31:0] key);
      send_byte(b0);
      case (form)
         0: send_byte({masked, len[6:0]});
         1: begin
            send_byte({masked, LEN_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: begin
            send_byte({masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
         end
      endcase
      if (masked)
         for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
   endtask

   function automatic logic [63:0] pick_len();
      int r;
      logic [63:0] n;
      r = $urandom_range(0, 99);
      if (r < 10) n = 64'd0;
      else if (r < 70) n = 64'($urandom_range(1, 8));
      else if (r < 90) n = 64'($urandom_range(9, 40));
      else if (r < 97) n = 64'($urandom_range(41, 200));
      else n = 64'($urandom_range(201, 300));
      // Hit the limit itself often when it is small.
      if (len_limit <= 300 && $urandom_range(0, 3) == 0) n = 64'(len_limit);
      if (n > len_limit) n = 64'($urandom_range(0, len_limit));
      return n;
   endfunction

   task automatic send_random_frame();
      logic [63:0] len;
      int form;
      len = pick_len();
      if (len >= 126) form = ($urandom_range(0, 3) == 0) ? 2 : 1;
      else begin
         form = $urandom_range(0, 9);
         form = (form < 7) ? 0 : (form < 9) ? 1 : 2;
      end
      send_header(8'($urandom_range(0, 255)), len, form, 1'($urandom_range(0, 1)),
                  $urandom);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin : main_proc
      logic [MAX_LEN_W-1:0] v;
      logic [63:0] len;
      logic [31:0] hi;
      int phase_end;
      int kind;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].ck, dir_rows[i].r);
      drain();

      for (int p = 0; p < 10; p++) begin
         v = (p == 9) ? MAX_LEN_W'($urandom) : lim_steps[p];
         write_limit(v);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         if (p == 1) begin
            req_gaps_on = 1'b0;
            stall_on = 1'b0;
         end
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end) send_random_frame();
         drain();
      end

      // The oversized frame locks the parser until reset, so it comes last.
      req_gaps_on = 1'b1;
      stall_on = 1'b1;
      v = MAX_LEN_W'($urandom_range(0, 124));
      write_limit(v);
      kind = $urandom_range(0, 2);
      case (kind)
         0: len = 64'(v) + 64'd1;
         1: len = 64'(v) + 64'd1 + 64'($urandom_range(0, 60000));
         default: begin
            // Upper half nonzero, lower half within the limit.
            hi = $urandom;
            if (hi == 0) hi = 32'd1;
            len = {hi, 32'($urandom_range(0, v))};
         end
      endcase
      send_header(8'($urandom_range(0, 255)), len, kind, 1'($urandom_range(0, 1)),
                  $urandom);
      repeat (24) send_byte(8'($urandom_range(0, 255)));
      drain();

      $display("Sent %0d stream bytes and checked %0d results under 11 length limits,",
               bytes_sent, results_checked);
      $display("finishing with an oversized frame and the bytes that follow it.");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/wsfp_pkg.sv
rtl/wsfp_parse.sv
rtl/websocket_frame_parser_top.sv
rtl/wsfp_checker.sv
sim/tb.sv
